// File: hw/rtl/stq_pkg.sv
// Shared types, codes and constants of the sorted timer queue.
package stq_pkg;

  localparam int TimerCount = 16;
  localparam int IdW        = 4;
  localparam int CntW       = 5;
  localparam int TimeW      = 32;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_SET    = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_PENDING     = 2'd1;
  localparam logic [1:0] ST_NOT_PENDING = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   timer_id;
    logic [30:0]      delay_ms;
    logic [TimeW-1:0] deadline;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    expired;
    logic [IdW-1:0]          expired_id;
    logic signed [TimeW-1:0] next_wait;
    logic                    last;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_REMOVE, S_SCAN, S_EXPIRE, S_WAIT, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_DECODE, OP_REMOVE, OP_SCAN, OP_EXPIRE, OP_WAIT, OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic out_take;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       pend_hit;
    logic       scan_more;
    logic       due;
    logic       out_last;
  } dp_stat_t;

  // True when a is strictly later than b by wrapping signed difference.
  function automatic logic is_later(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW-1:0] d;
    d = a - b;
    return (d != '0) && !d[TimeW-1];
  endfunction

endpackage

// File: hw/rtl/stq_ctrl.sv
// Controller state machine of the sorted timer queue.
module stq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_stall_i,
  input  stq_pkg::dp_stat_t stat_i,
  output stq_pkg::ctrl_cmd_t cmd_o,
  output logic              in_stall_o,
  output logic              out_valid_o
);
  import stq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.kind)
          KIND_ADD:    state_d = stat_i.pend_hit ? S_WAIT : S_SCAN;
          KIND_SET:    state_d = stat_i.pend_hit ? S_REMOVE : S_SCAN;
          KIND_CANCEL: state_d = stat_i.pend_hit ? S_REMOVE : S_WAIT;
          default:     state_d = S_EXPIRE;
        endcase
      end
      S_REMOVE: begin
        state_d = (stat_i.kind == KIND_SET) ? S_SCAN : S_WAIT;
      end
      S_SCAN: begin
        if (!stat_i.scan_more) state_d = S_WAIT;
      end
      S_EXPIRE: begin
        if (!stat_i.due) state_d = S_WAIT;
      end
      S_WAIT: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i && stat_i.out_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.out_take = 1'b0;
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_DECODE: cmd_o.op = OP_DECODE;
      S_REMOVE: cmd_o.op = OP_REMOVE;
      S_SCAN:   cmd_o.op = OP_SCAN;
      S_EXPIRE: cmd_o.op = OP_EXPIRE;
      S_WAIT:   cmd_o.op = OP_WAIT;
      S_OUT: begin
        cmd_o.op       = OP_OUT;
        out_valid_o    = 1'b1;
        cmd_o.out_take = !out_stall_i;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: hw/rtl/stq_datapath.sv
// Datapath of the sorted timer queue: time counter, sorted list and result words.
module stq_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stq_pkg::in_word_t   in_word_i,
  input  stq_pkg::ctrl_cmd_t  cmd_i,
  output stq_pkg::dp_stat_t   stat_o,
  output stq_pkg::out_word_t  out_word_o
);
  import stq_pkg::*;

  logic [1:0]       kind_q;
  logic [IdW-1:0]   id_q;
  logic [30:0]      delay_q;
  logic [TimeW-1:0] dl_q;
  logic [1:0]       status_q;
  logic [TimeW-1:0] time_q;
  logic [TimerCount-1:0] pend_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  pos_q;
  logic [CntW-1:0]  nfired_q;
  logic [CntW-1:0]  out_idx_q;
  logic [TimeW-1:0] wait_q;
  logic [IdW-1:0]   ent_id_q [TimerCount];
  logic [TimeW-1:0] ent_dl_q [TimerCount];
  logic [IdW-1:0]   fired_q  [TimerCount];

  logic [TimerCount-1:0] match;
  logic [TimerCount-1:0] after;
  logic [IdW-1:0]   pos_idx;
  logic             scan_more;
  logic             due;
  logic [TimeW-1:0] head_diff;
  logic [CntW-1:0]  out_next;

  assign pos_idx   = pos_q[IdW-1:0];
  assign scan_more = (pos_q < count_q) && !is_later(ent_dl_q[pos_idx], dl_q);
  assign due       = (count_q != '0) && !is_later(ent_dl_q[0], time_q);
  assign head_diff = ent_dl_q[0] - time_q;
  assign out_next  = out_idx_q + CntW'(1);

  // The entry holding the removed id and everything behind it move up by one.
  always_comb begin
    for (int k = 0; k < TimerCount; k++) begin
      match[k] = (CntW'(k) < count_q) && (ent_id_q[k] == id_q);
    end
    after[0] = match[0];
    for (int k = 1; k < TimerCount; k++) begin
      after[k] = after[k-1] | match[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      pend_q  <= '0;
      count_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_DECODE: begin
          if (kind_q == KIND_TICK) time_q <= time_q + TimeW'(1);
        end
        OP_REMOVE: begin
          count_q     <= count_q - CntW'(1);
          pend_q[id_q] <= 1'b0;
        end
        OP_SCAN: begin
          if (!scan_more && (count_q < CntW'(TimerCount))) begin
            count_q      <= count_q + CntW'(1);
            pend_q[id_q] <= 1'b1;
          end
        end
        OP_EXPIRE: begin
          if (due) begin
            count_q             <= count_q - CntW'(1);
            pend_q[ent_id_q[0]] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        kind_q  <= in_word_i.kind;
        id_q    <= in_word_i.timer_id;
        delay_q <= in_word_i.delay_ms;
        dl_q    <= in_word_i.deadline;
      end
      OP_DECODE: begin
        if (kind_q == KIND_SET) dl_q <= time_q + {1'b0, delay_q};
        pos_q    <= '0;
        nfired_q <= '0;
        if (kind_q == KIND_ADD && pend_q[id_q]) begin
          status_q <= ST_PENDING;
        end else if (kind_q == KIND_CANCEL && !pend_q[id_q]) begin
          status_q <= ST_NOT_PENDING;
        end else begin
          status_q <= ST_OK;
        end
      end
      OP_REMOVE: begin
        pos_q <= '0;
        for (int k = 0; k < TimerCount - 1; k++) begin
          if (after[k]) begin
            ent_id_q[k] <= ent_id_q[k+1];
            ent_dl_q[k] <= ent_dl_q[k+1];
          end
        end
      end
      OP_SCAN: begin
        if (scan_more) begin
          pos_q <= pos_q + CntW'(1);
        end else if (count_q < CntW'(TimerCount)) begin
          for (int k = 1; k < TimerCount; k++) begin
            if (CntW'(k) > pos_q) begin
              ent_id_q[k] <= ent_id_q[k-1];
              ent_dl_q[k] <= ent_dl_q[k-1];
            end
          end
          ent_id_q[pos_idx] <= id_q;
          ent_dl_q[pos_idx] <= dl_q;
        end
      end
      OP_EXPIRE: begin
        if (due) begin
          fired_q[nfired_q[IdW-1:0]] <= ent_id_q[0];
          nfired_q <= nfired_q + CntW'(1);
          for (int k = 0; k < TimerCount - 1; k++) begin
            ent_id_q[k] <= ent_id_q[k+1];
            ent_dl_q[k] <= ent_dl_q[k+1];
          end
        end
      end
      OP_WAIT: begin
        out_idx_q <= '0;
        if (count_q == '0) begin
          wait_q <= '1;
        end else if (head_diff[TimeW-1]) begin
          wait_q <= '0;
        end else begin
          wait_q <= head_diff;
        end
      end
      OP_OUT: begin
        if (cmd_i.out_take) out_idx_q <= out_next;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_word_o.expired    = (nfired_q != '0);
    out_word_o.status     = out_word_o.expired ? ST_OK : status_q;
    out_word_o.expired_id = out_word_o.expired ? fired_q[out_idx_q[IdW-1:0]] : '0;
    out_word_o.next_wait  = wait_q;
    out_word_o.last       = out_word_o.expired ? (out_next == nfired_q) : 1'b1;
  end

  assign stat_o.kind      = kind_q;
  assign stat_o.pend_hit  = pend_q[id_q];
  assign stat_o.scan_more = scan_more;
  assign stat_o.due       = due;
  assign stat_o.out_last  = out_word_o.last;

endmodule

// File: hw/rtl/sorted_timer_queue.sv
// Top level of the sorted timer queue.
// Usage: each input word is one command: add (absolute deadline), set
// (relative delay), cancel, or tick (advance the millisecond counter by one).
// The block keeps up to 16 timers in a list sorted by deadline; equal
// deadlines keep insertion order. Every command yields one or more output
// words; the final one has last set. A tick yields one word per fired timer
// in list order, or one plain word if none is due. Every word carries the
// wait until the earliest remaining deadline, 0 if overdue, -1 if empty.
// Operation: one word is processed at a time. A command is loaded and
// decoded, then runs a remove if needed, then if needed the sorted insert
// that walks the list entry by entry (up to 16 entries), or for a tick the
// expiry sweep that fires due timers one by one from the head, then it
// computes the wait and hands out its output words in turn. No new input
// word is taken before the last one is through: the input stalls until the
// last output word of the command is taken; an output stall holds the
// current word. Reset empties the list, clears all pending flags and sets
// the time to zero.
module sorted_timer_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  stq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stq_pkg::out_word_t out_word_o
);
  import stq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  stq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  stq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule
